// ===== rtl/core/ece_pkg.sv =====
// shared types, constants and fixed-point helpers for the ecef/enu converter
package ece_pkg;

   localparam int CoordW  = 34;
   localparam int FactW   = 32;
   localparam int OperW   = 37;
   localparam int ProdW   = OperW + FactW;
   localparam int MulW    = ProdW - 30;
   localparam int OrgW    = 36;
   localparam int SumW    = 40;
   localparam int AngW    = 35;
   localparam int CordW   = 33;
   localparam int CsrIdxW = 2;
   localparam int CsrDataW = 33;

   localparam logic [CsrIdxW-1:0] RegLat    = 2'd0;
   localparam logic [CsrIdxW-1:0] RegLon    = 2'd1;
   localparam logic [CsrIdxW-1:0] RegHeight = 2'd2;

   localparam logic CmdToEnu  = 1'b0;
   localparam logic CmdToEcef = 1'b1;

   localparam logic signed [FactW-1:0] QOne       = 32'sd1073741824;
   localparam logic signed [FactW-1:0] QE2        = 32'sd7188036;
   localparam logic signed [FactW-1:0] QOneMinusE2 = 32'sd1066553788;
   localparam logic signed [FactW-1:0] CordicGain = 32'sd652032874;
   localparam logic signed [AngW-1:0]  PiQ        = 35'sd3373259426;
   localparam logic signed [AngW-1:0]  TwoPiQ     = 35'sd6746518852;
   localparam logic signed [AngW-1:0]  HalfPiQ    = 35'sd1686629713;
   localparam logic [63:0] WgsAShift = 64'd6378137000 << 30;
   localparam logic signed [SumW-1:0]   OutMax    = 40'sd8589934591;
   localparam logic signed [CoordW-1:0] OutMaxC   = 34'sd8589934591;
   localparam logic signed [ProdW-1:0]  RoundHalf = ProdW'(64'sd536870912);

   typedef struct packed {
      logic                     cmd;
      logic signed [CoordW-1:0] x;
      logic signed [CoordW-1:0] y;
      logic signed [CoordW-1:0] z;
   } req_type;

   typedef struct packed {
      logic signed [CoordW-1:0] x;
      logic signed [CoordW-1:0] y;
      logic signed [CoordW-1:0] z;
      logic                     sat;
   } rsp_type;

   typedef struct packed {
      logic signed [FactW-1:0] clat;
      logic signed [FactW-1:0] slat;
      logic signed [FactW-1:0] clon;
      logic signed [FactW-1:0] slon;
      logic signed [OrgW-1:0]  u0;
      logic signed [OrgW-1:0]  v0;
      logic signed [OrgW-1:0]  w0;
   } origin_type;

   function automatic logic [29:0] atan_q30(input logic [4:0] idx);
      logic [29:0] r;
      case (idx)
         5'd0:  r = 30'd843314857;
         5'd1:  r = 30'd497837829;
         5'd2:  r = 30'd263043837;
         5'd3:  r = 30'd133525159;
         5'd4:  r = 30'd67021687;
         5'd5:  r = 30'd33543516;
         5'd6:  r = 30'd16775851;
         5'd7:  r = 30'd8388437;
         5'd8:  r = 30'd4194283;
         5'd9:  r = 30'd2097149;
         5'd10: r = 30'd1048576;
         5'd11: r = 30'd524288;
         5'd12: r = 30'd262144;
         5'd13: r = 30'd131072;
         5'd14: r = 30'd65536;
         5'd15: r = 30'd32768;
         5'd16: r = 30'd16384;
         5'd17: r = 30'd8192;
         5'd18: r = 30'd4096;
         5'd19: r = 30'd2048;
         5'd20: r = 30'd1024;
         5'd21: r = 30'd512;
         5'd22: r = 30'd256;
         5'd23: r = 30'd128;
         5'd24: r = 30'd64;
         5'd25: r = 30'd32;
         5'd26: r = 30'd16;
         5'd27: r = 30'd8;
         5'd28: r = 30'd4;
         5'd29: r = 30'd2;
         5'd30: r = 30'd1;
         default: r = 30'd0;
      endcase
      return r;
   endfunction

   // q30 product, rounded half up
   function automatic logic signed [MulW-1:0] mulq(input logic signed [OperW-1:0] a,
                                                   input logic signed [FactW-1:0] b);
      logic signed [ProdW-1:0] p;
      p = ProdW'(a) * ProdW'(b);
      p = p + RoundHalf;
      return MulW'(p >>> 30);
   endfunction

   // saturate to the coordinate range, flag in the top bit
   function automatic logic [CoordW:0] clamp(input logic signed [SumW-1:0] v);
      logic [CoordW:0] r;
      if (v > OutMax) begin
         r = {1'b1, OutMaxC};
      end else if (v < -OutMax) begin
         r = {1'b1, -OutMaxC};
      end else begin
         r = {1'b0, v[CoordW-1:0]};
      end
      return r;
   endfunction

endpackage

// ===== rtl/core/ece_fifo.sv =====
// small first-in first-out queue
module ece_fifo #(
   parameter int Width = 8,
   parameter int Depth = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [Width-1:0] push_data,
   input  logic             pop,
   output logic [Width-1:0] pop_data,
   output logic             empty,
   output logic             full
);

   localparam int PtrW = $clog2(Depth);
   localparam int CntW = PtrW + 1;

   logic [Width-1:0] mem_ff [Depth];
   logic [CntW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [CntW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic             do_push, do_pop;

   assign empty = wr_ptr_ff == rd_ptr_ff;
   assign full  = (wr_ptr_ff[PtrW] != rd_ptr_ff[PtrW]) &&
                  (wr_ptr_ff[PtrW-1:0] == rd_ptr_ff[PtrW-1:0]);
   assign do_push   = push && !full;
   assign do_pop    = pop && !empty;
   assign wr_ptr_in = wr_ptr_ff + CntW'(do_push);
   assign rd_ptr_in = rd_ptr_ff + CntW'(do_pop);
   assign pop_data  = mem_ff[rd_ptr_ff[PtrW-1:0]];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff[PtrW-1:0]] <= push_data;
      end
   end

endmodule

// ===== rtl/core/ece_origin.sv =====
// origin registers and setup sequencer: sin/cos, prime-vertical radius, origin in ecef
module ece_origin #(
   parameter int ANGLE_ITERATIONS = 24
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_wen,
   input  logic [ece_pkg::CsrIdxW-1:0]  csr_index,
   input  logic [ece_pkg::CsrDataW-1:0] csr_wdata,
   output logic                         busy,
   output ece_pkg::origin_type          origin
);

   localparam int IterW = $clog2(ANGLE_ITERATIONS);
   localparam int AngW  = ece_pkg::AngW;
   localparam int CordW = ece_pkg::CordW;
   localparam int FactW = ece_pkg::FactW;
   localparam int OperW = ece_pkg::OperW;
   localparam int MulW  = ece_pkg::MulW;
   localparam int OrgW  = ece_pkg::OrgW;
   localparam logic [IterW-1:0] IterLast = IterW'(ANGLE_ITERATIONS - 1);

   typedef enum logic [3:0] {
      ST_PREP, ST_CORDIC, ST_SQ, ST_E2, ST_SQRT, ST_DINIT, ST_DIV,
      ST_VAL, ST_U0, ST_V0, ST_W1, ST_W0, ST_DONE
   } state_type;

   state_type               state_ff;
   logic signed [31:0]      lat_ff;
   logic signed [32:0]      lon_ff;
   logic signed [27:0]      hgt_ff;
   logic [IterW-1:0]        it_ff;
   logic signed [CordW-1:0] lat_x_ff, lat_y_ff, lon_x_ff, lon_y_ff;
   logic signed [AngW-1:0]  lat_z_ff, lon_z_ff;
   logic                    lat_flip_ff, lon_flip_ff;
   logic signed [FactW-1:0] clat_ff, slat_ff, clon_ff, slon_ff;
   logic signed [MulW-1:0]  m_ff;
   logic [63:0]             sq_n_ff, sq_r_ff, sq_bit_ff;
   logic [63:0]             div_num_ff;
   logic [31:0]             div_rem_ff;
   logic [5:0]              div_cnt_ff;
   logic signed [OrgW-1:0]  u0_ff, v0_ff, w0_ff;

   logic [AngW:0]           lat_red, lon_red;
   logic signed [AngW-1:0]  atan_v;
   logic signed [CordW-1:0] lat_x_in, lat_y_in, lon_x_in, lon_y_in;
   logic signed [AngW-1:0]  lat_z_in, lon_z_in;
   logic signed [OperW-1:0] mul_a;
   logic signed [FactW-1:0] mul_b;
   logic signed [MulW-1:0]  mul_r;
   logic signed [FactW-1:0] t_val;
   logic signed [33:0]      n0;
   logic [63:0]             sq_sum;
   logic [32:0]             div_shift;
   logic                    div_ge;

   function automatic logic [AngW:0] reduce(input logic signed [AngW-1:0] a);
      logic signed [AngW-1:0] v;
      logic                   flip;
      v    = a;
      flip = 1'b0;
      if (v > ece_pkg::PiQ) begin
         v = v - ece_pkg::TwoPiQ;
      end
      if (v < -ece_pkg::PiQ) begin
         v = v + ece_pkg::TwoPiQ;
      end
      if (v > ece_pkg::HalfPiQ) begin
         v    = v - ece_pkg::PiQ;
         flip = 1'b1;
      end else if (v < -ece_pkg::HalfPiQ) begin
         v    = v + ece_pkg::PiQ;
         flip = 1'b1;
      end
      return {flip, v};
   endfunction

   assign lat_red = reduce(AngW'(lat_ff));
   assign lon_red = reduce(AngW'(lon_ff));
   assign atan_v  = $signed({5'd0, ece_pkg::atan_q30(5'(it_ff))});

   // one rotation step for both angles
   always_comb begin
      if (!lat_z_ff[AngW-1]) begin
         lat_x_in = lat_x_ff - (lat_y_ff >>> it_ff);
         lat_y_in = lat_y_ff + (lat_x_ff >>> it_ff);
         lat_z_in = lat_z_ff - atan_v;
      end else begin
         lat_x_in = lat_x_ff + (lat_y_ff >>> it_ff);
         lat_y_in = lat_y_ff - (lat_x_ff >>> it_ff);
         lat_z_in = lat_z_ff + atan_v;
      end
      if (!lon_z_ff[AngW-1]) begin
         lon_x_in = lon_x_ff - (lon_y_ff >>> it_ff);
         lon_y_in = lon_y_ff + (lon_x_ff >>> it_ff);
         lon_z_in = lon_z_ff - atan_v;
      end else begin
         lon_x_in = lon_x_ff + (lon_y_ff >>> it_ff);
         lon_y_in = lon_y_ff - (lon_x_ff >>> it_ff);
         lon_z_in = lon_z_ff + atan_v;
      end
   end

   assign n0 = $signed({1'b0, div_num_ff[32:0]});

   // shared multiplier
   always_comb begin
      case (state_ff)
         ST_SQ: begin
            mul_a = OperW'(slat_ff);
            mul_b = slat_ff;
         end
         ST_E2: begin
            mul_a = OperW'(m_ff);
            mul_b = ece_pkg::QE2;
         end
         ST_VAL: begin
            mul_a = OperW'(n0) + OperW'(hgt_ff);
            mul_b = clat_ff;
         end
         ST_U0: begin
            mul_a = OperW'(m_ff);
            mul_b = clon_ff;
         end
         ST_V0: begin
            mul_a = OperW'(m_ff);
            mul_b = slon_ff;
         end
         ST_W1: begin
            mul_a = OperW'(n0);
            mul_b = ece_pkg::QOneMinusE2;
         end
         ST_W0: begin
            mul_a = OperW'(m_ff);
            mul_b = slat_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_r     = ece_pkg::mulq(mul_a, mul_b);
   assign t_val     = ece_pkg::QOne - FactW'(mul_r);
   assign sq_sum    = sq_r_ff + sq_bit_ff;
   assign div_shift = {div_rem_ff, div_num_ff[63]};
   assign div_ge    = div_shift >= sq_r_ff[32:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_PREP;
         lat_ff   <= '0;
         lon_ff   <= '0;
         hgt_ff   <= '0;
      end else if (csr_wen) begin
         case (csr_index)
            ece_pkg::RegLat:    lat_ff <= csr_wdata[31:0];
            ece_pkg::RegLon:    lon_ff <= csr_wdata;
            ece_pkg::RegHeight: hgt_ff <= csr_wdata[27:0];
            default: ;
         endcase
         state_ff <= ST_PREP;
      end else begin
         case (state_ff)
            ST_PREP: begin
               lat_x_ff    <= CordW'(ece_pkg::CordicGain);
               lat_y_ff    <= '0;
               lat_z_ff    <= lat_red[AngW-1:0];
               lat_flip_ff <= lat_red[AngW];
               lon_x_ff    <= CordW'(ece_pkg::CordicGain);
               lon_y_ff    <= '0;
               lon_z_ff    <= lon_red[AngW-1:0];
               lon_flip_ff <= lon_red[AngW];
               it_ff       <= '0;
               state_ff    <= ST_CORDIC;
            end
            ST_CORDIC: begin
               lat_x_ff <= lat_x_in;
               lat_y_ff <= lat_y_in;
               lat_z_ff <= lat_z_in;
               lon_x_ff <= lon_x_in;
               lon_y_ff <= lon_y_in;
               lon_z_ff <= lon_z_in;
               it_ff    <= it_ff + 1'b1;
               clat_ff  <= FactW'(lat_flip_ff ? -lat_x_in : lat_x_in);
               slat_ff  <= FactW'(lat_flip_ff ? -lat_y_in : lat_y_in);
               clon_ff  <= FactW'(lon_flip_ff ? -lon_x_in : lon_x_in);
               slon_ff  <= FactW'(lon_flip_ff ? -lon_y_in : lon_y_in);
               if (it_ff == IterLast) begin
                  state_ff <= ST_SQ;
               end
            end
            ST_SQ: begin
               m_ff     <= mul_r;
               state_ff <= ST_E2;
            end
            ST_E2: begin
               sq_n_ff   <= {2'b00, t_val, 30'd0};
               sq_r_ff   <= '0;
               sq_bit_ff <= 64'h4000_0000_0000_0000;
               state_ff  <= ST_SQRT;
            end
            ST_SQRT: begin
               if (sq_n_ff >= sq_sum) begin
                  sq_n_ff <= sq_n_ff - sq_sum;
                  sq_r_ff <= (sq_r_ff >> 1) + sq_bit_ff;
               end else begin
                  sq_r_ff <= sq_r_ff >> 1;
               end
               sq_bit_ff <= sq_bit_ff >> 2;
               if (sq_bit_ff[0]) begin
                  state_ff <= ST_DINIT;
               end
            end
            ST_DINIT: begin
               div_num_ff <= ece_pkg::WgsAShift + (sq_r_ff >> 1);
               div_rem_ff <= '0;
               div_cnt_ff <= '0;
               state_ff   <= ST_DIV;
            end
            ST_DIV: begin
               div_rem_ff <= 32'(div_ge ? div_shift - sq_r_ff[32:0] : div_shift);
               div_num_ff <= {div_num_ff[62:0], div_ge};
               div_cnt_ff <= div_cnt_ff + 1'b1;
               if (div_cnt_ff == 6'd63) begin
                  state_ff <= ST_VAL;
               end
            end
            ST_VAL: begin
               m_ff     <= mul_r;
               state_ff <= ST_U0;
            end
            ST_U0: begin
               u0_ff    <= OrgW'(mul_r);
               state_ff <= ST_V0;
            end
            ST_V0: begin
               v0_ff    <= OrgW'(mul_r);
               state_ff <= ST_W1;
            end
            ST_W1: begin
               m_ff     <= mul_r + MulW'(hgt_ff);
               state_ff <= ST_W0;
            end
            ST_W0: begin
               w0_ff    <= OrgW'(mul_r);
               state_ff <= ST_DONE;
            end
            default: begin
               state_ff <= ST_DONE;
            end
         endcase
      end
   end

   assign busy        = state_ff != ST_DONE;
   assign origin.clat = clat_ff;
   assign origin.slat = slat_ff;
   assign origin.clon = clon_ff;
   assign origin.slon = slon_ff;
   assign origin.u0   = u0_ff;
   assign origin.v0   = v0_ff;
   assign origin.w0   = w0_ff;

endmodule

// ===== rtl/core/ece_xform.sv =====
// five-stage translate and rotate pipeline, one request per cycle
module ece_xform (
   input  logic                clock,
   input  logic                reset,
   input  logic                issue,
   input  ece_pkg::req_type    req,
   input  ece_pkg::origin_type origin,
   output logic                out_valid,
   output ece_pkg::rsp_type    out
);

   localparam int OperW  = ece_pkg::OperW;
   localparam int FactW  = ece_pkg::FactW;
   localparam int MulW   = ece_pkg::MulW;
   localparam int SumW   = ece_pkg::SumW;
   localparam int CoordW = ece_pkg::CoordW;

   logic                    v1_ff, v2_ff, v3_ff, v4_ff, out_valid_ff;
   logic                    c1_ff, c2_ff, c3_ff, c4_ff;
   logic signed [OperW-1:0] a0_ff, a1_ff, a2_ff;
   logic signed [MulW-1:0]  m0_ff, m1_ff, m2_ff, m3_ff;
   logic signed [OperW-1:0] k2_ff, k3_ff;
   logic signed [SumW-1:0]  p3_ff, e3_ff, e4_ff;
   logic signed [MulW-1:0]  n0_ff, n1_ff, n2_ff, n3_ff;
   ece_pkg::rsp_type        out_ff;

   logic                    to_ecef1, to_ecef2, to_ecef3, to_ecef4;
   logic signed [OperW-1:0] op_a, op_b, op_c, op_d;
   logic signed [FactW-1:0] fc, fs, gc, gs;
   logic signed [SumW-1:0]  d4, s4, rx, ry, rz;
   logic [CoordW:0]         cx, cy, cz;

   assign to_ecef1 = req.cmd == ece_pkg::CmdToEcef;
   assign to_ecef2 = c1_ff == ece_pkg::CmdToEcef;
   assign to_ecef3 = c2_ff == ece_pkg::CmdToEcef;
   assign to_ecef4 = c3_ff == ece_pkg::CmdToEcef;

   assign fc   = to_ecef2 ? origin.clat : origin.clon;
   assign fs   = to_ecef2 ? origin.slat : origin.slon;
   assign op_a = to_ecef2 ? a2_ff : a0_ff;
   assign gc   = to_ecef4 ? origin.clon : origin.clat;
   assign gs   = to_ecef4 ? origin.slon : origin.slat;
   assign op_c = to_ecef4 ? OperW'(p3_ff) : k3_ff;
   assign op_d = to_ecef4 ? k3_ff : OperW'(p3_ff);
   assign op_b = a1_ff;

   assign d4 = SumW'(n0_ff) - SumW'(n1_ff);
   assign s4 = SumW'(n2_ff) + SumW'(n3_ff);

   always_comb begin
      if (c4_ff == ece_pkg::CmdToEcef) begin
         rx = d4 + SumW'(origin.u0);
         ry = s4 + SumW'(origin.v0);
         rz = e4_ff;
      end else begin
         rx = e4_ff;
         ry = d4;
         rz = s4;
      end
   end

   assign cx = ece_pkg::clamp(rx);
   assign cy = ece_pkg::clamp(ry);
   assign cz = ece_pkg::clamp(rz);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         v1_ff        <= issue;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         v4_ff        <= v3_ff;
         out_valid_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      // translate for ecef to local
      c1_ff <= req.cmd;
      if (to_ecef1) begin
         a0_ff <= OperW'(req.x);
         a1_ff <= OperW'(req.y);
         a2_ff <= OperW'(req.z);
      end else begin
         a0_ff <= OperW'(req.x) - OperW'(origin.u0);
         a1_ff <= OperW'(req.y) - OperW'(origin.v0);
         a2_ff <= OperW'(req.z) - OperW'(origin.w0);
      end
      // first rotation
      c2_ff <= c1_ff;
      m0_ff <= ece_pkg::mulq(op_a, fc);
      m1_ff <= ece_pkg::mulq(op_b, fs);
      m2_ff <= ece_pkg::mulq(op_b, fc);
      m3_ff <= ece_pkg::mulq(op_a, fs);
      k2_ff <= to_ecef2 ? a0_ff : a2_ff;
      // combine
      c3_ff <= c2_ff;
      k3_ff <= k2_ff;
      if (to_ecef3) begin
         p3_ff <= SumW'(m0_ff) - SumW'(m1_ff);
         e3_ff <= SumW'(m2_ff) + SumW'(m3_ff) + SumW'(origin.w0);
      end else begin
         p3_ff <= SumW'(m0_ff) + SumW'(m1_ff);
         e3_ff <= SumW'(m2_ff) - SumW'(m3_ff);
      end
      // second rotation
      c4_ff <= c3_ff;
      e4_ff <= e3_ff;
      n0_ff <= ece_pkg::mulq(op_c, gc);
      n1_ff <= ece_pkg::mulq(op_d, gs);
      n2_ff <= ece_pkg::mulq(op_d, gc);
      n3_ff <= ece_pkg::mulq(op_c, gs);
      // clamp
      out_ff.x   <= cx[CoordW-1:0];
      out_ff.y   <= cy[CoordW-1:0];
      out_ff.z   <= cz[CoordW-1:0];
      out_ff.sat <= cx[CoordW] | cy[CoordW] | cz[CoordW];
   end

   assign out_valid = out_valid_ff;
   assign out       = out_ff;

endmodule

// ===== rtl/core/ecef_enu_converter_core.sv =====
// top level: ecef <-> local east-north-up converter about a configured origin
//
//   channel   direction   handshake          payload
//   request   in          push / full        req_cmd, req_in_x, req_in_y, req_in_z
//   result    out         empty / pop        rsp_out_x, rsp_out_y, rsp_out_z, rsp_saturated
//   csr       in          csr_wen            csr_index, csr_wdata
//
// one request per cycle sustained while results are popped; a request taken passes
// through the request queue and then five pipeline stages into the result queue.
// after reset and after every csr write the origin sequencer runs (cordic, 32-step
// square root, 64-step divide) and holds full high meanwhile.
// issue from the request queue stops once results in flight or waiting fill the
// result queue; the request side keeps taking requests until the request queue fills.
module ecef_enu_converter_core #(
   parameter int ANGLE_ITERATIONS = 24,
   parameter int REQ_DEPTH = 4,
   parameter int RSP_DEPTH = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                push,
   output logic                                full,
   input  logic                                req_cmd,
   input  logic signed [ece_pkg::CoordW-1:0]   req_in_x,
   input  logic signed [ece_pkg::CoordW-1:0]   req_in_y,
   input  logic signed [ece_pkg::CoordW-1:0]   req_in_z,
   output logic                                empty,
   input  logic                                pop,
   output logic signed [ece_pkg::CoordW-1:0]   rsp_out_x,
   output logic signed [ece_pkg::CoordW-1:0]   rsp_out_y,
   output logic signed [ece_pkg::CoordW-1:0]   rsp_out_z,
   output logic                                rsp_saturated,
   input  logic                                csr_wen,
   input  logic [ece_pkg::CsrIdxW-1:0]         csr_index,
   input  logic [ece_pkg::CsrDataW-1:0]        csr_wdata
);

   localparam int CrW = $clog2(RSP_DEPTH + 1);

   ece_pkg::req_type    req_in, req_head;
   ece_pkg::rsp_type    xf_out, rsp_head;
   ece_pkg::origin_type origin;
   logic                busy, reqq_empty, reqq_full, rspq_full;
   logic                issue, xf_valid;
   logic [CrW-1:0]      credit_ff, credit_in;

   assign req_in.cmd = req_cmd;
   assign req_in.x   = req_in_x;
   assign req_in.y   = req_in_y;
   assign req_in.z   = req_in_z;

   ece_origin #(
      .ANGLE_ITERATIONS(ANGLE_ITERATIONS)
   ) u_origin (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .busy      (busy),
      .origin    (origin)
   );

   ece_fifo #(
      .Width ($bits(ece_pkg::req_type)),
      .Depth (REQ_DEPTH)
   ) u_req_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push && !busy),
      .push_data (req_in),
      .pop       (issue),
      .pop_data  (req_head),
      .empty     (reqq_empty),
      .full      (reqq_full)
   );

   // results in flight or waiting never exceed the result queue
   assign issue     = !reqq_empty && (credit_ff != CrW'(RSP_DEPTH));
   assign credit_in = credit_ff + CrW'(issue) - CrW'(pop && !empty);

   always_ff @(posedge clock) begin
      if (reset) begin
         credit_ff <= '0;
      end else begin
         credit_ff <= credit_in;
      end
   end

   ece_xform u_xform (
      .clock     (clock),
      .reset     (reset),
      .issue     (issue),
      .req       (req_head),
      .origin    (origin),
      .out_valid (xf_valid),
      .out       (xf_out)
   );

   ece_fifo #(
      .Width ($bits(ece_pkg::rsp_type)),
      .Depth (RSP_DEPTH)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (xf_valid),
      .push_data (xf_out),
      .pop       (pop),
      .pop_data  (rsp_head),
      .empty     (empty),
      .full      (rspq_full)
   );

   assign full          = reqq_full || busy || (rspq_full && 1'b0);
   assign rsp_out_x     = rsp_head.x;
   assign rsp_out_y     = rsp_head.y;
   assign rsp_out_z     = rsp_head.z;
   assign rsp_saturated = rsp_head.sat;

endmodule

// ===== rtl/core/ece_checker.sv =====
// port-level checks for the converter, bound to the top level
module ece_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              full,
   input logic                              empty,
   input logic                              pop,
   input logic signed [ece_pkg::CoordW-1:0] rsp_out_x,
   input logic signed [ece_pkg::CoordW-1:0] rsp_out_y,
   input logic signed [ece_pkg::CoordW-1:0] rsp_out_z,
   input logic                              rsp_saturated,
   input logic                              csr_wen
);

   // origin setup runs after reset
   a_full_after_reset: assert property (@(posedge clock) reset |=> full)
      else $error("full low right after reset");

   // origin setup runs after a csr write
   a_full_after_csr: assert property (@(posedge clock) disable iff (reset)
      csr_wen |=> full)
      else $error("full low right after csr write");

   a_empty_after_reset: assert property (@(posedge clock) reset |=> empty)
      else $error("result present right after reset");

   // a clamped result sits on a range limit
   a_sat_on_limit: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_saturated) |->
         (rsp_out_x == ece_pkg::OutMaxC || rsp_out_x == -ece_pkg::OutMaxC ||
          rsp_out_y == ece_pkg::OutMaxC || rsp_out_y == -ece_pkg::OutMaxC ||
          rsp_out_z == ece_pkg::OutMaxC || rsp_out_z == -ece_pkg::OutMaxC))
      else $error("saturated without a clamped coordinate");

   a_hold_result: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_out_x) && $stable(rsp_out_y) &&
                            $stable(rsp_out_z) && $stable(rsp_saturated)))
      else $error("waiting result changed");

endmodule

bind ecef_enu_converter_core ece_checker u_checker (
   .clock         (clock),
   .reset         (reset),
   .full          (full),
   .empty         (empty),
   .pop           (pop),
   .rsp_out_x     (rsp_out_x),
   .rsp_out_y     (rsp_out_y),
   .rsp_out_z     (rsp_out_z),
   .rsp_saturated (rsp_saturated),
   .csr_wen       (csr_wen)
);

// ===== test/ecef_enu_converter_checker.sv =====
// checker for the ecef/enu converter: predicts each result and compares it with the block
module ecef_enu_converter_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                push,
   input  logic                                full,
   input  logic                                req_cmd,
   input  logic signed [ece_pkg::CoordW-1:0]   req_in_x,
   input  logic signed [ece_pkg::CoordW-1:0]   req_in_y,
   input  logic signed [ece_pkg::CoordW-1:0]   req_in_z,
   input  logic                                empty,
   input  logic                                pop,
   input  logic signed [ece_pkg::CoordW-1:0]   rsp_out_x,
   input  logic signed [ece_pkg::CoordW-1:0]   rsp_out_y,
   input  logic signed [ece_pkg::CoordW-1:0]   rsp_out_z,
   input  logic                                rsp_saturated,
   input  logic                                csr_wen,
   input  logic [ece_pkg::CsrIdxW-1:0]         csr_index,
   input  logic [ece_pkg::CsrDataW-1:0]        csr_wdata,
   output int                                  error_count,
   output int                                  pending
);

   localparam int CordicSteps = 24;
   localparam longint OneQ = 64'sd1073741824;
   localparam longint PiVal = 64'sd3373259426;
   localparam longint HalfPiVal = 64'sd1686629713;
   localparam longint CoordMax = 64'sd8589934591;

   longint arctan_tab [0:31] = '{
      843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
      16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
      65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32,
      16, 8, 4, 2, 1, 0};

   longint lat_q, lon_q, height_mm;
   ece_pkg::rsp_type expected_results[$];

   assign pending = expected_results.size();

   function automatic longint scale_q30(input longint a, input longint b);
      logic signed [127:0] p;
      p = a;
      p = p * b + 128'sd536870912;
      return longint'(p >>> 30);
   endfunction

   function automatic void rotate_angle(input longint ang, output longint c,
                                        output longint s);
      longint x, y, z, dx, dy;
      bit flip;
      flip = 0;
      x = 64'sd652032874;
      y = 0;
      if (ang > PiVal) ang -= 2 * PiVal;
      if (ang < -PiVal) ang += 2 * PiVal;
      if (ang > HalfPiVal) begin
         ang -= PiVal;
         flip = 1;
      end else if (ang < -HalfPiVal) begin
         ang += PiVal;
         flip = 1;
      end
      z = ang;
      for (int i = 0; i < CordicSteps; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x -= dx;
            y += dy;
            z -= arctan_tab[i];
         end else begin
            x += dx;
            y -= dy;
            z += arctan_tab[i];
         end
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
   endfunction

   function automatic logic [63:0] int_sqrt(input logic [63:0] n);
      logic [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   function automatic longint clip_coord(input longint v, inout bit sat);
      if (v > CoordMax) begin
         sat = 1;
         return CoordMax;
      end
      if (v < -CoordMax) begin
         sat = 1;
         return -CoordMax;
      end
      return v;
   endfunction

   function automatic ece_pkg::rsp_type convert_point(input logic cmd, input longint px,
                                                      input longint py, input longint pz);
      longint clat, slat, clon, slon, t, n0, val, u0, v0, w0, p, rx, ry, rz;
      longint du, dv, dw;
      logic [63:0] q;
      bit sat;
      ece_pkg::rsp_type r;
      sat = 0;
      rotate_angle(lat_q, clat, slat);
      rotate_angle(lon_q, clon, slon);
      t = OneQ - scale_q30(64'sd7188036, scale_q30(slat, slat));
      q = int_sqrt(64'(t) << 30);
      n0 = longint'(((64'd6378137000 << 30) + (q >> 1)) / q);
      val = scale_q30(n0 + height_mm, clat);
      u0 = scale_q30(val, clon);
      v0 = scale_q30(val, slon);
      w0 = scale_q30(scale_q30(n0, OneQ - 64'sd7188036) + height_mm, slat);
      if (cmd == ece_pkg::CmdToEnu) begin
         du = px - u0;
         dv = py - v0;
         dw = pz - w0;
         p = scale_q30(du, clon) + scale_q30(dv, slon);
         rx = scale_q30(dv, clon) - scale_q30(du, slon);
         ry = scale_q30(dw, clat) - scale_q30(p, slat);
         rz = scale_q30(p, clat) + scale_q30(dw, slat);
      end else begin
         p = scale_q30(pz, clat) - scale_q30(py, slat);
         rx = scale_q30(p, clon) - scale_q30(px, slon) + u0;
         ry = scale_q30(px, clon) + scale_q30(p, slon) + v0;
         rz = scale_q30(py, clat) + scale_q30(pz, slat) + w0;
      end
      r.x = ece_pkg::CoordW'(clip_coord(rx, sat));
      r.y = ece_pkg::CoordW'(clip_coord(ry, sat));
      r.z = ece_pkg::CoordW'(clip_coord(rz, sat));
      r.sat = sat;
      return r;
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
      error_count++;
   endtask

   initial error_count = 0;

   always @(posedge clock) begin
      ece_pkg::rsp_type want;
      if (reset) begin
         lat_q <= 0;
         lon_q <= 0;
         height_mm <= 0;
         expected_results.delete();
      end else begin
         if (csr_wen) begin
            case (csr_index)
               ece_pkg::RegLat:    lat_q <= longint'($signed(csr_wdata[31:0]));
               ece_pkg::RegLon:    lon_q <= longint'($signed(csr_wdata[32:0]));
               ece_pkg::RegHeight: height_mm <= longint'($signed(csr_wdata[27:0]));
               default: ;
            endcase
         end
         if (pop && !empty) begin
            if (expected_results.size() == 0) begin
               report_mismatch("unexpected result, x", rsp_out_x, 0);
            end else begin
               want = expected_results.pop_front();
               if (rsp_out_x !== want.x) report_mismatch("out_x", rsp_out_x, want.x);
               if (rsp_out_y !== want.y) report_mismatch("out_y", rsp_out_y, want.y);
               if (rsp_out_z !== want.z) report_mismatch("out_z", rsp_out_z, want.z);
               if (rsp_saturated !== want.sat)
                  report_mismatch("saturated", rsp_saturated, want.sat);
            end
         end
         if (push && !full)
            expected_results.push_back(convert_point(req_cmd, req_in_x, req_in_y, req_in_z));
      end
   end

endmodule

// ===== test/ecef_enu_converter_core_tb.sv =====
// testbench top: stimulus, idling and verdict for the ecef/enu converter core
module ecef_enu_converter_core_tb;

   logic clock, reset;
   logic push, full, req_cmd;
   logic signed [ece_pkg::CoordW-1:0] req_in_x, req_in_y, req_in_z;
   logic empty, pop;
   logic signed [ece_pkg::CoordW-1:0] rsp_out_x, rsp_out_y, rsp_out_z;
   logic rsp_saturated;
   logic csr_wen;
   logic [ece_pkg::CsrIdxW-1:0] csr_index;
   logic [ece_pkg::CsrDataW-1:0] csr_wdata;
   int error_count, pending;
   int send_idle_pct, recv_stall_pct, hold_cycles;

   ecef_enu_converter_core uut (.*);

   ecef_enu_converter_checker checker_i (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      #3000000;
      $display("DONE: errors detected");
      $finish;
   end

   // receiver: random stalls, long hold-off when requested
   always @(posedge clock) begin
      if (reset) begin
         pop <= 0;
      end else if (hold_cycles > 0) begin
         pop <= 0;
         hold_cycles <= hold_cycles - 1;
      end else begin
         pop <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   function automatic logic [ece_pkg::CoordW-1:0] random_coord();
      logic [63:0] v;
      int w;
      w = $urandom_range(ece_pkg::CoordW, 1);
      v = {$urandom, $urandom};
      if ($urandom_range(9) == 0) return $urandom_range(1) ? {1'b1, 33'd0} : {1'b0, {33{1'b1}}};
      return ece_pkg::CoordW'($signed(v << (64 - w)) >>> (64 - w));
   endfunction

   task automatic send_request(input logic cmd, input logic [ece_pkg::CoordW-1:0] x,
                               input logic [ece_pkg::CoordW-1:0] y,
                               input logic [ece_pkg::CoordW-1:0] z);
      logic blocked;
      while ($urandom_range(99) < send_idle_pct) begin
         push <= 0;
         @(posedge clock);
      end
      push <= 1;
      req_cmd <= cmd;
      req_in_x <= x;
      req_in_y <= y;
      req_in_z <= z;
      // full only moves at the rising edge, so the falling edge shows the edge's value
      do begin
         @(negedge clock);
         blocked = full;
         @(posedge clock);
      end while (blocked);
   endtask

   task automatic write_origin(input logic [31:0] lat, input logic [32:0] lon,
                               input logic [27:0] hgt);
      push <= 0;
      @(posedge clock);
      wait (pending == 0);
      @(posedge clock);
      csr_wen <= 1;
      csr_index <= ece_pkg::RegLat;
      csr_wdata <= {1'($urandom), lat};
      @(posedge clock);
      csr_index <= ece_pkg::RegLon;
      csr_wdata <= lon;
      @(posedge clock);
      csr_index <= ece_pkg::RegHeight;
      csr_wdata <= {5'($urandom), hgt};
      @(posedge clock);
      csr_wen <= 0;
   endtask

   initial begin
      logic [ece_pkg::CoordW-1:0] edges [4];
      edges = '{{1'b1, 33'd0}, {1'b0, {33{1'b1}}}, '0, '1};
      reset = 1;
      push = 0;
      req_cmd = 0;
      req_in_x = 0;
      req_in_y = 0;
      req_in_z = 0;
      csr_wen = 0;
      csr_index = ece_pkg::RegLat;
      csr_wdata = 0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_cycles = 0;
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // field extremes, both directions, zero origin
      for (int i = 0; i < 4; i++) begin
         send_request(ece_pkg::CmdToEnu, edges[i], edges[(i + 1) % 4], edges[(i + 2) % 4]);
         send_request(ece_pkg::CmdToEcef, edges[i], edges[(i + 3) % 4], edges[(i + 1) % 4]);
      end
      write_origin(32'sd1686629713, 33'sd3373259426, 28'sd100000000);
      for (int i = 0; i < 4; i++) send_request(1'(i), edges[i], edges[i], edges[3 - i]);
      write_origin(-32'sd1686629713, -33'sd3373259426, -28'sd1000000);
      for (int i = 0; i < 4; i++) send_request(1'(i), edges[3 - i], edges[i], edges[i]);

      for (int ph = 0; ph < 8; ph++) begin
         case (ph)
            0: write_origin({1'b1, 31'd0}, {1'b1, 32'd0}, {1'b1, 27'd0});
            1: write_origin({1'b0, {31{1'b1}}}, {1'b0, {32{1'b1}}}, {1'b0, {27{1'b1}}});
            2: write_origin(32'sd1686629713, -33'sd3373259426, 28'sd100000000);
            3: write_origin(32'(-$urandom_range(1686629713)), 33'($urandom_range(32'hc90fdaa2)),
                            28'($urandom_range(100000000)));
            default: write_origin($urandom, {1'($urandom), $urandom}, 28'($urandom));
         endcase
         send_idle_pct = (ph % 4 == 1 || ph % 4 == 3) ? (ph % 4 == 1 ? 87 : 10) : 0;
         recv_stall_pct = (ph % 4 == 2 || ph % 4 == 3) ? (ph % 4 == 2 ? 87 : 10) : 0;
         for (int n = 0; n < 190; n++) begin
            if (ph == 0 && n == 20) hold_cycles <= 300;
            if (ph == 4 && n == 95) begin
               push <= 0;
               @(posedge clock);
               wait (pending == 0);
               @(posedge clock);
            end
            send_request(1'($urandom), random_coord(), random_coord(), random_coord());
         end
      end
      push <= 0;
      wait (pending == 0);
      repeat (20) @(posedge clock);
      if (error_count == 0 && pending == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
